// ===== rtl/core/elevation_grid_ground_split_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Elevation grid ground split assertion macros
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ELEVATION_GRID_GROUND_SPLIT_UNIT_ASSERT_SVH
`define ELEVATION_GRID_GROUND_SPLIT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define EGS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elevation grid check failed");
// next-cycle implication
`define EGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elevation grid check failed");
`else
`define EGS_ASSERT_SAME(label, clk, rst, ante, cons)
`define EGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/egs_pkg.sv =====
// ---------------------------------------------------------------------------
// Elevation grid ground split package
// Shared widths, codes and bundles of the elevation grid unit.
// ---------------------------------------------------------------------------
`default_nettype none

package egs_pkg;

  localparam int COORD_BITS   = 32;
  localparam int CPM_BITS     = 24;
  localparam int DIM_BITS     = 9;
  localparam int THR_BITS     = 20;
  localparam int IDX_BITS     = 18;
  localparam int OUT_IDX_BITS = 16;
  localparam int CLASS_BITS   = 2;
  localparam int REG_IDX_BITS = 3;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = DIFF_BITS + CPM_BITS;
  localparam int Q_SHIFT      = 26;
  localparam int Q_BITS       = PROD_BITS - Q_SHIFT;

  localparam logic [COORD_BITS-1:0] MIN_RESET = 32'h7FFF_FFFF;

  localparam logic KIND_INSERT   = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [CLASS_BITS-1:0] CLASS_GROUND   = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_OBSTACLE = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_SPARSE   = 2'd2;
  localparam logic [CLASS_BITS-1:0] CLASS_OUTSIDE  = 2'd3;

  localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X         = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Y         = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CELLS_PER_METRE  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_GRID_COLUMNS     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_GRID_ROWS        = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_GROUND_THRESHOLD = 3'd5;

  typedef struct packed {
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [CPM_BITS-1:0]   cells_per_metre;
    logic [DIM_BITS-1:0]   grid_columns;
    logic [DIM_BITS-1:0]   grid_rows;
    logic [THR_BITS-1:0]   ground_threshold;
  } egs_cfg_t;

  typedef struct packed {
    logic                outside;
    logic [IDX_BITS-1:0] idx;
  } egs_loc_t;

endpackage

`default_nettype wire

// ===== rtl/core/egs_cell_mem.sv =====
// ---------------------------------------------------------------------------
// Elevation grid cell store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module egs_cell_mem #(
  parameter int DEPTH     = 65536,
  parameter int ADDR_BITS = 16,
  parameter int WIDTH     = 48
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/egs_map.sv =====
// ---------------------------------------------------------------------------
// Elevation grid coordinate mapper
// Four-stage pipeline from point x, y to linear cell index and range flag.
// ---------------------------------------------------------------------------
`default_nettype none

module egs_map #(
  parameter int MAX_CELLS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [egs_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [egs_pkg::COORD_BITS-1:0] point_y,
  input  egs_pkg::egs_cfg_t                    cfg,
  output logic                                 out_valid,
  output egs_pkg::egs_loc_t                    loc
);

  import egs_pkg::*;

  logic [3:0] vld;

  logic [DIFF_BITS-1:0] diff_x;
  logic [DIFF_BITS-1:0] diff_y;
  logic                 neg_x1;
  logic                 neg_y1;
  logic [DIFF_BITS-1:0] mag_x1;
  logic [DIFF_BITS-1:0] mag_y1;

  logic                 neg_x2;
  logic                 neg_y2;
  logic [PROD_BITS-1:0] prod_x2;
  logic [PROD_BITS-1:0] prod_y2;

  logic [Q_BITS-1:0]    q_x;
  logic [Q_BITS-1:0]    q_y;
  logic [Q_BITS-1:0]    col_full;
  logic [Q_BITS-1:0]    row_full;
  logic                 bad_x;
  logic                 bad_y;
  logic                 over_x;
  logic                 over_y;

  logic                 outside3;
  logic [DIM_BITS-1:0]  col3;
  logic [DIM_BITS-1:0]  row3;

  logic [IDX_BITS-1:0]  idx_full;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign diff_x = {point_x[COORD_BITS-1], point_x} - {cfg.origin_x[COORD_BITS-1], cfg.origin_x};
  assign diff_y = {point_y[COORD_BITS-1], point_y} - {cfg.origin_y[COORD_BITS-1], cfg.origin_y};

  always_ff @(posedge clk) begin
    neg_x1 <= diff_x[DIFF_BITS-1];
    neg_y1 <= diff_y[DIFF_BITS-1];
    mag_x1 <= diff_x[DIFF_BITS-1] ? (~diff_x + DIFF_BITS'(1)) : diff_x;
    mag_y1 <= diff_y[DIFF_BITS-1] ? (~diff_y + DIFF_BITS'(1)) : diff_y;
  end

  always_ff @(posedge clk) begin
    neg_x2  <= neg_x1;
    neg_y2  <= neg_y1;
    prod_x2 <= PROD_BITS'(mag_x1) * PROD_BITS'(cfg.cells_per_metre);
    prod_y2 <= PROD_BITS'(mag_y1) * PROD_BITS'(cfg.cells_per_metre);
  end

  assign q_x      = prod_x2[PROD_BITS-1:Q_SHIFT];
  assign q_y      = prod_y2[PROD_BITS-1:Q_SHIFT];
  assign bad_x    = neg_x2 && (q_x != '0);
  assign bad_y    = neg_y2 && (q_y != '0);
  assign col_full = neg_x2 ? '0 : q_x;
  assign row_full = neg_y2 ? '0 : q_y;
  assign over_x   = col_full >= Q_BITS'(cfg.grid_columns);
  assign over_y   = row_full >= Q_BITS'(cfg.grid_rows);

  always_ff @(posedge clk) begin
    outside3 <= bad_x || bad_y || over_x || over_y;
    col3     <= col_full[DIM_BITS-1:0];
    row3     <= row_full[DIM_BITS-1:0];
  end

  assign idx_full = IDX_BITS'(row3) * IDX_BITS'(cfg.grid_columns) + IDX_BITS'(col3);
  assign fits     = 32'(idx_full) < 32'(MAX_CELLS);

  always_ff @(posedge clk) begin
    loc.outside <= outside3 || !fits;
    loc.idx     <= idx_full;
  end

  assign out_valid = vld[3];

endmodule

`default_nettype wire

// ===== rtl/core/elevation_grid_ground_split_unit.sv =====
// ---------------------------------------------------------------------------
// Elevation grid ground split unit
// Keeps per-cell minimum height and point count; inserts and classifies points.
//
//   channel   handshake              payload
//   --------  ---------------------  ---------------------------------------
//   command   start / busy           kind, point_x, point_y, point_z
//   result    done (one cycle)       cell_index, point_class
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A point inside the grid passes the mapping pipeline, a memory read and a
// read-modify-write before the next accept; a point outside skips the
// read-modify-write. After reset the store is swept, one cell a cycle over
// all MAX_CELLS cells, with busy high; configuration writes are taken
// meanwhile.
// done follows the last busy cycle of an item; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

`include "elevation_grid_ground_split_unit_assert.svh"

module elevation_grid_ground_split_unit #(
  parameter int MAX_CELLS  = 65536,
  parameter int COUNT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind,
  input  logic signed [egs_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [egs_pkg::COORD_BITS-1:0]  point_y,
  input  logic signed [egs_pkg::COORD_BITS-1:0]  point_z,
  output logic                                   done,
  output logic [egs_pkg::OUT_IDX_BITS-1:0]       cell_index,
  output logic [egs_pkg::CLASS_BITS-1:0]         point_class,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [egs_pkg::REG_IDX_BITS-1:0]       cfg_index,
  input  logic [egs_pkg::COORD_BITS-1:0]         cfg_data
);

  import egs_pkg::*;

  localparam int ADDR_BITS = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int WORD_BITS = COORD_BITS + COUNT_BITS;
  localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(MAX_CELLS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MAP    = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]            state;
  logic [ADDR_BITS-1:0]  clr_addr;
  egs_cfg_t              cfg;
  logic                  accept;

  logic                  kind_q;
  logic [COORD_BITS-1:0] z_q;
  logic [IDX_BITS-1:0]   idx_q;

  logic                  map_valid;
  egs_loc_t              loc;

  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;

  logic [COORD_BITS-1:0] cur_min;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COORD_BITS-1:0] new_min;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [DIFF_BITS-1:0]  limit;
  logic                  low_enough;
  logic [CLASS_BITS-1:0] upd_class;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x         <= '0;
      cfg.origin_y         <= '0;
      cfg.cells_per_metre  <= CPM_BITS'(327680);
      cfg.grid_columns     <= DIM_BITS'(256);
      cfg.grid_rows        <= DIM_BITS'(256);
      cfg.ground_threshold <= THR_BITS'(205);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:         cfg.origin_x         <= cfg_data;
        REG_ORIGIN_Y:         cfg.origin_y         <= cfg_data;
        REG_CELLS_PER_METRE:  cfg.cells_per_metre  <= cfg_data[CPM_BITS-1:0];
        REG_GRID_COLUMNS:     cfg.grid_columns     <= cfg_data[DIM_BITS-1:0];
        REG_GRID_ROWS:        cfg.grid_rows        <= cfg_data[DIM_BITS-1:0];
        REG_GROUND_THRESHOLD: cfg.ground_threshold <= cfg_data[THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  egs_map #(
    .MAX_CELLS (MAX_CELLS)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .point_x   (point_x),
    .point_y   (point_y),
    .cfg       (cfg),
    .out_valid (map_valid),
    .loc       (loc)
  );

  assign cur_min = mem_rdata[WORD_BITS-1:COUNT_BITS];
  assign cur_cnt = mem_rdata[COUNT_BITS-1:0];
  assign new_min = ($signed(z_q) < $signed(cur_min)) ? z_q : cur_min;
  assign new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
  assign limit   = {cur_min[COORD_BITS-1], cur_min} + DIFF_BITS'(cfg.ground_threshold);
  assign low_enough = $signed({z_q[COORD_BITS-1], z_q}) <= $signed(limit);

  always_comb begin
    if (kind_q == KIND_INSERT) begin
      upd_class = CLASS_GROUND;
    end else if (low_enough) begin
      upd_class = CLASS_GROUND;
    end else if (cur_cnt >= COUNT_BITS'(2)) begin
      upd_class = CLASS_OBSTACLE;
    end else begin
      upd_class = CLASS_SPARSE;
    end
  end

  assign mem_raddr = ADDR_BITS'(loc.idx);
  assign mem_we    = (state == ST_CLEAR) || ((state == ST_UPDATE) && (kind_q == KIND_INSERT));
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : ADDR_BITS'(idx_q);
  assign mem_wdata = (state == ST_CLEAR) ? {MIN_RESET, COUNT_BITS'(0)} : {new_min, new_cnt};

  egs_cell_mem #(
    .DEPTH     (MAX_CELLS),
    .ADDR_BITS (ADDR_BITS),
    .WIDTH     (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            kind_q <= kind;
            z_q    <= point_z;
            state  <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (map_valid) begin
            if (loc.outside) begin
              done        <= 1'b1;
              cell_index  <= '0;
              point_class <= CLASS_OUTSIDE;
              state       <= ST_IDLE;
            end else begin
              idx_q <= loc.idx;
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          done        <= 1'b1;
          cell_index  <= idx_q[OUT_IDX_BITS-1:0];
          point_class <= upd_class;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `EGS_ASSERT_SAME(a_done_when_free, clk, rst, done, !busy)
  `EGS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `EGS_ASSERT_SAME(a_write_in_work, clk, rst, mem_we, (state == ST_CLEAR) || (state == ST_UPDATE))
  `EGS_ASSERT_SAME(a_outside_index, clk, rst, done && (point_class == CLASS_OUTSIDE), cell_index == '0)

endmodule

`default_nettype wire
